FILE: design/u8enc_pkg.sv
// Shared types and constants for the UCS-32 to UTF-8 encoder.
`default_nettype none
package u8enc_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NUL   = 2'd1;
	localparam logic [1:0] ST_BIT31 = 2'd2;
	localparam logic [1:0] ST_WARN  = 2'd3;

	localparam logic [31:0] UNICODE_MAX = 32'h0010_FFFF;

	// One classified code point, ready to serialize.
	typedef struct packed {
		logic [7:0]  lead_byte;
		logic [29:0] payload;
		logic [2:0]  nbytes;
		logic [1:0]  status;
		logic        send;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

FILE: design/u8enc_front.sv
// Front end: accepts code points, classifies them and pushes descriptors.
`default_nettype none
module u8enc_front
	import u8enc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] code_point,
	input  wire logic        string_end_in,
	input  wire logic        pedantic_q,
	input  wire q_stat_t     q_stat,
	output logic             push,
	output desc_t            push_desc
);

	logic  valid_s1;
	desc_t desc_s1;
	desc_t desc_d;
	logic  take;
	logic  warn;

	assign busy      = valid_s1 & q_stat.full;
	assign take      = start & ~busy;
	assign push      = valid_s1 & ~q_stat.full;
	assign push_desc = desc_s1;

	assign warn = pedantic_q & (code_point > UNICODE_MAX);

	always_comb begin
		desc_d.payload = code_point[29:0];
		desc_d.send    = string_end_in;
		desc_d.status  = warn ? ST_WARN : ST_OK;
		if (code_point == 32'd0) begin
			desc_d.nbytes    = 3'd1;
			desc_d.lead_byte = 8'h00;
			desc_d.status    = ST_NUL;
		end else if (code_point[31]) begin
			desc_d.nbytes    = 3'd1;
			desc_d.lead_byte = 8'h00;
			desc_d.status    = ST_BIT31;
		end else if (code_point[30:7] == '0) begin
			desc_d.nbytes    = 3'd1;
			desc_d.lead_byte = {1'b0, code_point[6:0]};
		end else if (code_point[30:11] == '0) begin
			desc_d.nbytes    = 3'd2;
			desc_d.lead_byte = {3'b110, code_point[10:6]};
		end else if (code_point[30:16] == '0) begin
			desc_d.nbytes    = 3'd3;
			desc_d.lead_byte = {4'b1110, code_point[15:12]};
		end else if (code_point[30:21] == '0) begin
			desc_d.nbytes    = 3'd4;
			desc_d.lead_byte = {5'b11110, code_point[20:18]};
		end else if (code_point[30:26] == '0) begin
			desc_d.nbytes    = 3'd5;
			desc_d.lead_byte = {6'b111110, code_point[25:24]};
		end else begin
			desc_d.nbytes    = 3'd6;
			desc_d.lead_byte = {7'b1111110, code_point[30]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			desc_s1 <= desc_d;
		end
	end

endmodule
`default_nettype wire

FILE: design/u8enc_queue.sv
// Small descriptor queue between the front end and the serializer.
`default_nettype none
module u8enc_queue
	import u8enc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	input  wire logic  pop,
	output desc_t      head,
	output q_stat_t    q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	desc_t         entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_stat.full  = (count_q == FULL_CNT);
	assign q_stat.empty = (count_q == '0);
	assign head         = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule
`default_nettype wire

FILE: design/u8enc_back.sv
// Back end: serializes one descriptor into UTF-8 bytes, one per cycle.
`default_nettype none
module u8enc_back
	import u8enc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire desc_t head,
	input  wire q_stat_t q_stat,
	output logic       pop,
	output logic       strobe,
	output logic [7:0] out_byte,
	output logic       last_of_char,
	output logic       string_end_out,
	output logic [1:0] status
);

	logic       active_q;
	desc_t      cur_q;
	logic [2:0] idx_q;
	logic [2:0] rem;
	logic       last_now;
	logic [5:0] slice;
	logic [7:0] byte_d;

	logic       strobe_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       send_q;
	logic [1:0] status_q;

	assign rem      = cur_q.nbytes - 3'd1 - idx_q;
	assign last_now = active_q && (rem == 3'd0);
	assign pop      = ~q_stat.empty & (~active_q | last_now);

	always_comb begin
		case (rem)
			3'd0:    slice = cur_q.payload[5:0];
			3'd1:    slice = cur_q.payload[11:6];
			3'd2:    slice = cur_q.payload[17:12];
			3'd3:    slice = cur_q.payload[23:18];
			3'd4:    slice = cur_q.payload[29:24];
			default: slice = 6'd0;
		endcase
		byte_d = (idx_q == 3'd0) ? cur_q.lead_byte : {2'b10, slice};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (last_now) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (active_q) begin
			byte_q   <= byte_d;
			last_q   <= last_now;
			send_q   <= last_now & cur_q.send;
			status_q <= cur_q.status;
		end
	end

	assign strobe         = strobe_q;
	assign out_byte       = byte_q;
	assign last_of_char   = last_q;
	assign string_end_out = send_q;
	assign status         = status_q;

endmodule
`default_nettype wire

FILE: design/ucs32_to_utf8_encoder_top.sv
// Top level of the UCS-32 to UTF-8 encoder (six-byte form).
//
// Usage: drive code_point and string_end_in with start high; the beat is
// taken at a rising edge where busy is low. Each code point comes out as
// 1 to 6 bytes, one per cycle, each shown for exactly one cycle with
// strobe high; the receiver cannot stall, so sample on every strobe.
// The final byte of a code point has last_of_char set and carries the
// input's string_end_in as string_end_out. A NUL code point or one with
// bit 31 set yields a single zero byte with status 1 or 2. With
// pedantic_warn set, every byte of a code point above 0x10FFFF without
// bit 31 set carries status 3. Rate: the serializer emits one byte per
// cycle, and single-byte characters stream at one per cycle while the
// queue holds descriptors. The front end takes a new beat each cycle
// while the descriptor queue (QUEUE_DEPTH entries) has room. An accepted
// beat passes the front-end register, a queue entry and the serializer's
// descriptor register before the output registers raise strobe. cfg_ready
// is always high; write pedantic_warn only while the block is idle.
`default_nettype none
module ucs32_to_utf8_encoder_top
	import u8enc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] code_point,
	input  wire logic        string_end_in,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	output logic             strobe,
	output logic [7:0]       out_byte,
	output logic             last_of_char,
	output logic             string_end_out,
	output logic [1:0]       status
);

	logic    pedantic_q;
	logic    push;
	desc_t   push_desc;
	logic    pop;
	desc_t   head;
	q_stat_t q_stat;

	// Configuration register: always ready, one beat writes it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pedantic_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			pedantic_q <= cfg_data;
		end
	end

	// Classify on entry; hold the descriptor until the queue has room.
	u8enc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.code_point    (code_point),
		.string_end_in (string_end_in),
		.pedantic_q    (pedantic_q),
		.q_stat        (q_stat),
		.push          (push),
		.push_desc     (push_desc)
	);

	// Decouple classification from serialization.
	u8enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// Serialize bytes and register them onto the result ports.
	u8enc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_stat         (q_stat),
		.pop            (pop),
		.strobe         (strobe),
		.out_byte       (out_byte),
		.last_of_char   (last_of_char),
		.string_end_out (string_end_out),
		.status         (status)
	);

	// Error results are single zero bytes.
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == ST_NUL || status == ST_BIT31)
			|-> last_of_char && (out_byte == 8'h00))
		else $error("error result is not a single zero byte");

	// End of string only on the final byte of a character.
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		string_end_out && strobe |-> last_of_char)
		else $error("string end flagged on a non-final byte");

	// Never push into a full queue unless it pops in the same cycle, nor pop an empty one.
	a_queue_safe: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full && !pop) && !(pop && q_stat.empty))
		else $error("descriptor queue overflow or underflow");

	// A byte after a non-final byte is a continuation byte.
	a_cont_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_of_char |=> strobe && (out_byte[7:6] == 2'b10))
		else $error("missing continuation byte");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the UCS-32 to UTF-8 encoder top level.
`timescale 1ns / 100ps

module testbench;
	import u8enc_pkg::*;

	// Cycles with no beat of any kind before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Settle time after the last byte.
	localparam int TAIL_CYCLES = 20;

	// Code points at the edges of every length class and of each error case.
	localparam logic [31:0] CORNER_CPS [22] = '{
		32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
		32'h0000_007F, 32'h0000_0080, 32'h0000_07FF, 32'h0000_0800,
		32'h0000_FFFF, 32'h0001_0000, 32'h0010_FFFF, 32'h0011_0000,
		32'h001F_FFFF, 32'h0020_0000, 32'h03FF_FFFF, 32'h0400_0000,
		32'h7FFF_FFFF, 32'h5555_5555, 32'h2AAA_AAAA, 32'hD555_5555,
		32'h0000_0000, 32'h8000_0001
	};

	typedef struct {
		logic [31:0] cp;
		logic        str_end;
	} code_point_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       str_end;
		logic [1:0] code;
	} utf8_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] code_point = '0;
	logic        string_end_in = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        strobe;
	logic [7:0]  out_byte;
	logic        last_of_char;
	logic        string_end_out;
	logic [1:0]  status;

	code_point_t code_points_to_send [$];
	utf8_beat_t  expected_bytes [$];
	logic        pedantic_mode = 1'b0;
	logic        gaps_on = 1'b1;
	int          errors = 0;
	int          quiet_cycles = 0;

	ucs32_to_utf8_encoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.code_point    (code_point),
		.string_end_in (string_end_in),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.strobe        (strobe),
		.out_byte      (out_byte),
		.last_of_char  (last_of_char),
		.string_end_out(string_end_out),
		.status        (status)
	);

	always #5 clk = ~clk;

	function automatic utf8_beat_t make_beat(logic [7:0] data, logic last, logic str_end,
			logic [1:0] code);
		utf8_beat_t b;
		b.data = data;
		b.last = last;
		b.str_end = last & str_end;
		b.code = code;
		return b;
	endfunction

	// Encode one code point into its expected byte stream, using the
	// pedantic setting in force when the beat was taken.
	task automatic predict_utf8_bytes(input logic [31:0] cp, input logic str_end);
		logic [1:0] code;
		logic [7:0] lead;
		int         nbytes;
		int         shift;
		code = ST_OK;
		if (cp == 32'd0) begin
			expected_bytes.push_back(make_beat(8'h00, 1'b1, str_end, ST_NUL));
			return;
		end
		if (cp[31]) begin
			expected_bytes.push_back(make_beat(8'h00, 1'b1, str_end, ST_BIT31));
			return;
		end
		if (pedantic_mode && cp > UNICODE_MAX)
			code = ST_WARN;
		if (cp <= 32'h7F) begin
			nbytes = 1;
			lead = {1'b0, cp[6:0]};
		end else if (cp <= 32'h7FF) begin
			nbytes = 2;
			lead = {3'b110, cp[10:6]};
		end else if (cp <= 32'hFFFF) begin
			nbytes = 3;
			lead = {4'b1110, cp[15:12]};
		end else if (cp <= 32'h1F_FFFF) begin
			nbytes = 4;
			lead = {5'b11110, cp[20:18]};
		end else if (cp <= 32'h3FF_FFFF) begin
			nbytes = 5;
			lead = {6'b111110, cp[25:24]};
		end else begin
			nbytes = 6;
			lead = {7'b1111110, cp[30]};
		end
		expected_bytes.push_back(make_beat(lead, nbytes == 1, str_end, code));
		for (int k = 1; k < nbytes; k++) begin
			shift = 6 * (nbytes - 1 - k);
			expected_bytes.push_back(make_beat({2'b10, 6'((cp >> shift) & 32'h3F)},
				k == nbytes - 1, str_end, code));
		end
	endtask

	// Driver: present the oldest pending code point, hold it until busy is
	// low at an edge, then advance. A new beat may be held back at random
	// while gaps are enabled.
	always @(posedge clk) begin : sender
		logic presenting;
		if (arst_n) begin
			presenting = start;
			if (start && !busy) begin
				predict_utf8_bytes(code_point, string_end_in);
				void'(code_points_to_send.pop_front());
				presenting = 1'b0;
			end
			if (!presenting) begin
				if (code_points_to_send.size() != 0 &&
						!(gaps_on && $urandom_range(99) < 11)) begin
					start <= 1'b1;
					code_point <= code_points_to_send[0].cp;
					string_end_in <= code_points_to_send[0].str_end;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Four-state compare so that unknown bits on the outputs count as a mismatch.
	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Monitor: every strobe is a byte that must match the oldest expectation.
	always @(posedge clk) begin : receiver
		utf8_beat_t want;
		if (arst_n && strobe) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual %h (last %b status %0d)",
					$time, out_byte, last_of_char, status);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				compare_field("out_byte", 32'(want.data), 32'(out_byte));
				compare_field("last_of_char", 32'(want.last), 32'(last_of_char));
				compare_field("string_end_out", 32'(want.str_end), 32'(string_end_out));
				compare_field("status", 32'(want.code), 32'(status));
			end
		end
	end

	// Watchdog: count edges at which no beat moves on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// Hold until every code point has been taken and every byte has come out.
	task automatic wait_drained();
		while (code_points_to_send.size() != 0 || start || expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Write the pedantic bit while the block is idle; the model follows at
	// the edge that takes the beat.
	task automatic write_pedantic(input logic value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		pedantic_mode = value;
		cfg_valid <= 1'b0;
	endtask

	// Queue random code points: mostly valid characters spread evenly over
	// the six length classes, plus error cases and values near 0x10FFFF.
	task automatic queue_random(input int count);
		code_point_t item;
		int          pick;
		int          nbytes;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(15);
			if (pick == 0) begin
				item.cp = 32'd0;
			end else if (pick == 1) begin
				item.cp = {1'b1, 31'($urandom)};
			end else if (pick == 2) begin
				item.cp = $urandom_range(32'h11_0003, 32'h10_FFFC);
			end else begin
				nbytes = $urandom_range(6, 1);
				case (nbytes)
					1: item.cp = $urandom_range(32'h7F, 32'h1);
					2: item.cp = $urandom_range(32'h7FF, 32'h80);
					3: item.cp = $urandom_range(32'hFFFF, 32'h800);
					4: item.cp = $urandom_range(32'h1F_FFFF, 32'h1_0000);
					5: item.cp = $urandom_range(32'h3FF_FFFF, 32'h20_0000);
					default: item.cp = $urandom_range(32'h7FFF_FFFF, 32'h400_0000);
				endcase
			end
			item.str_end = ($urandom_range(3) == 0);
			code_points_to_send.push_back(item);
		end
	endtask

	initial begin
		code_point_t item;
		// Hold reset from the start of the run, then release it once.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners with the reset setting (no warnings).
		foreach (CORNER_CPS[i]) begin
			item.cp = CORNER_CPS[i];
			item.str_end = (i % 3 == 2);
			code_points_to_send.push_back(item);
		end

		// Pedantic on: characters above 0x10FFFF now carry the warning.
		write_pedantic(1'b1);
		queue_random(40);

		// Pedantic off, back-to-back beats with no gaps to fill the queue.
		write_pedantic(1'b0);
		gaps_on = 1'b0;
		queue_random(30);

		// Pedantic on again, with gaps.
		write_pedantic(1'b1);
		gaps_on = 1'b1;
		queue_random(8);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_bytes.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: ucs32_to_utf8_encoder_top.f
design/u8enc_pkg.sv
design/u8enc_front.sv
design/u8enc_queue.sv
design/u8enc_back.sv
design/ucs32_to_utf8_encoder_top.sv
verif/testbench.sv
